// ----- rtl/sofd_pkg.sv -----
package sofd_pkg;

  localparam int unsigned MAX_FRAME_DEF = 32;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned INDEX_W       = 5;
  localparam int unsigned OUT_TDATA_W   = 16;
  localparam int unsigned CFG_INDEX_W   = 2;

  // Frame layout: two start bytes, length, type, payload, checksum.
  localparam int unsigned HEADER_BYTES  = 4;
  localparam int unsigned FRAME_EXTRA   = 3;
  localparam int unsigned NON_PAYLOAD   = 5;
  localparam int unsigned MIN_LENGTH    = 3;

  localparam logic [BYTE_W-1:0] SOF_FIRST_RST  = 8'h5A;
  localparam logic [BYTE_W-1:0] SOF_SECOND_RST = 8'hA5;
  localparam logic [BYTE_W-1:0] FRAME_TYPE_RST = 8'hAA;

  localparam logic [CFG_INDEX_W-1:0] REG_SOF_FIRST  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SOF_SECOND = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_TYPE = 2'd2;

  typedef enum logic [2:0] {
    ST_SOF_FIRST,
    ST_SOF_SECOND,
    ST_LENGTH,
    ST_TYPE,
    ST_BODY
  } parse_state_t;

  // Per-cell control: capture a payload byte, load the output stage, shift it.
  typedef struct packed {
    logic wr_en;
    logic load;
    logic shift;
  } cell_ctl_t;

endpackage

// ----- rtl/sofd_cell.sv -----
module sofd_cell
  import sofd_pkg::*;
(
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [BYTE_W-1:0] wr_byte,
  input  logic [BYTE_W-1:0] nbr_byte,
  output logic [BYTE_W-1:0] out_byte
);

  logic [BYTE_W-1:0] cap_r;
  logic [BYTE_W-1:0] out_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      cap_r <= wr_byte;
    end
    // The output stage is loaded from the capture stage when a frame passes,
    // then walks one cell toward the output per delivered beat.
    if (ctl.load) begin
      out_r <= cap_r;
    end else if (ctl.shift) begin
      out_r <= nbr_byte;
    end
  end

  assign out_byte = out_r;

endmodule

// ----- rtl/sof_length_checksum_deframer.sv -----
// Start-of-frame / length / checksum deframer.
// Input channel (in_*): one received byte per beat in in_tdata. The block
// hunts for two start bytes, a length byte L, a type byte, L-2 payload bytes
// and an 8-bit additive checksum over all bytes before it.
// Output channel (out_*): for a frame with a good checksum, every payload
// byte as one beat, with its payload position; out_tlast marks the final one.
// Configuration (cfg_*): index 0 first start byte, 1 second start byte,
// 2 frame type byte; cfg_ready is always high. Other indexes are ignored.
// Throughput: one input byte per cycle. The payload sits in a row of cells;
// on a checksum beat that matches, it is copied into the cells' output stages
// and shifted out one beat per cycle while out_tready is high, first result
// in the cycle after the checksum beat. The input stalls only on a checksum
// beat while the previous frame's payload is still draining, so a stalled
// receiver holds the row and then the input. Reset: hunt restarts at the first
// start byte, registers take their defaults, nothing is pending on the output.
module sof_length_checksum_deframer
  import sofd_pkg::*;
#(
  parameter int unsigned MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [BYTE_W-1:0]      in_tdata,   // [7:0] rx_byte
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [7:0] payload_byte, [12:8] payload_index
  output logic                   out_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]      cfg_data
);

  localparam int unsigned DEPTH = MAX_FRAME - NON_PAYLOAD;
  localparam int unsigned PW    = $clog2(MAX_FRAME + 1);
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  logic [BYTE_W-1:0] sof_first_r;
  logic [BYTE_W-1:0] sof_second_r;
  logic [BYTE_W-1:0] frame_type_r;

  parse_state_t      state_r, state_nxt;
  logic [PW-1:0]     pos_r, pos_nxt;
  logic [PW-1:0]     len_r, len_nxt;
  logic [BYTE_W-1:0] sum_r, sum_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;

  logic              in_fire;
  logic              out_fire;
  logic              at_check;
  logic              wr_en;
  logic              load;
  logic [PW-1:0]     wr_idx;
  logic [8:0]        len_plus;
  logic [CW+4:0]     idx_ext;
  logic [BYTE_W-1:0] chain [DEPTH+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sof_first_r  <= SOF_FIRST_RST;
      sof_second_r <= SOF_SECOND_RST;
      frame_type_r <= FRAME_TYPE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SOF_FIRST:  sof_first_r  <= cfg_data;
        REG_SOF_SECOND: sof_second_r <= cfg_data;
        REG_FRAME_TYPE: frame_type_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign at_check  = (state_r == ST_BODY) && (pos_r == len_r - PW'(1));
  assign in_tready = !(at_check && (cnt_r != '0));
  assign in_fire   = in_tvalid && in_tready;
  assign out_tvalid = (cnt_r != '0);
  assign out_fire   = out_tvalid && out_tready;
  assign len_plus   = {1'b0, in_tdata} + 9'(FRAME_EXTRA);
  assign wr_idx     = pos_r - PW'(HEADER_BYTES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SOF_FIRST;
      pos_r   <= '0;
      len_r   <= '0;
      sum_r   <= '0;
      cnt_r   <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      len_r   <= len_nxt;
      sum_r   <= sum_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    len_nxt   = len_r;
    sum_nxt   = sum_r;
    wr_en     = 1'b0;
    load      = 1'b0;
    if (in_fire) begin
      unique case (state_r)
        ST_SOF_FIRST: begin
          if (in_tdata == sof_first_r) begin
            state_nxt = ST_SOF_SECOND;
            sum_nxt   = in_tdata;
          end
        end
        ST_SOF_SECOND: begin
          if (in_tdata == sof_second_r) begin
            state_nxt = ST_LENGTH;
            sum_nxt   = sum_r + in_tdata;
          end else begin
            state_nxt = ST_SOF_FIRST;
            sum_nxt   = '0;
          end
        end
        ST_LENGTH: begin
          // A frame too short to carry a payload byte, or too long for the store,
          // is treated like a bad start byte.
          if (in_tdata >= BYTE_W'(MIN_LENGTH) && len_plus <= 9'(MAX_FRAME)) begin
            state_nxt = ST_TYPE;
            len_nxt   = len_plus[PW-1:0];
            sum_nxt   = sum_r + in_tdata;
          end else begin
            state_nxt = ST_SOF_FIRST;
            sum_nxt   = '0;
            len_nxt   = '0;
          end
        end
        ST_TYPE: begin
          if (in_tdata == frame_type_r) begin
            state_nxt = ST_BODY;
            pos_nxt   = PW'(HEADER_BYTES);
            sum_nxt   = sum_r + in_tdata;
          end else begin
            state_nxt = ST_SOF_FIRST;
            sum_nxt   = '0;
            len_nxt   = '0;
          end
        end
        ST_BODY: begin
          if (at_check) begin
            load      = (in_tdata == sum_r);
            state_nxt = ST_SOF_FIRST;
            pos_nxt   = '0;
            len_nxt   = '0;
            sum_nxt   = '0;
          end else begin
            wr_en   = 1'b1;
            sum_nxt = sum_r + in_tdata;
            pos_nxt = pos_r + PW'(1);
          end
        end
        default: begin
          state_nxt = ST_SOF_FIRST;
        end
      endcase
    end
  end

  // A load only happens while the output row is empty, so it never meets a shift.
  always_comb begin
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    if (load) begin
      cnt_nxt = CW'(len_r - PW'(NON_PAYLOAD));
      idx_nxt = '0;
    end else if (out_fire) begin
      cnt_nxt = cnt_r - CW'(1);
      idx_nxt = idx_r + CW'(1);
    end
  end

  assign chain[DEPTH] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_ctl_t ctl;
    assign ctl.wr_en = wr_en && (wr_idx == PW'(i));
    assign ctl.load  = load;
    assign ctl.shift = out_fire;

    sofd_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .wr_byte  (in_tdata),
      .nbr_byte (chain[i+1]),
      .out_byte (chain[i])
    );
  end

  assign idx_ext   = {5'b0, idx_r};
  assign out_tdata = {3'b0, idx_ext[INDEX_W-1:0], chain[0]};
  assign out_tlast = (cnt_r == CW'(1));

endmodule

// ----- dv/tb_sof_length_checksum_deframer.sv -----
module tb_sof_length_checksum_deframer
  import sofd_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_FRAME     = MAX_FRAME_DEF;
  localparam int unsigned STORE_DEPTH   = MAX_FRAME - NON_PAYLOAD;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned RUN_LIMIT     = 200000;
  localparam int unsigned PHASE_BYTES   = 52;
  localparam int unsigned MAX_GAP       = 11;
  // Index outside the register map; the block has to ignore it.
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 2'd3;

  typedef struct {
    logic [BYTE_W-1:0] data;
    int unsigned       gap;
  } rx_beat_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  pay;
    logic [INDEX_W-1:0] idx;
    logic               last;
  } payload_beat_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [BYTE_W-1:0]      in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [BYTE_W-1:0]      cfg_data;

  sof_length_checksum_deframer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Register copies used for both prediction and stimulus.
  logic [BYTE_W-1:0] sof_first  = SOF_FIRST_RST;
  logic [BYTE_W-1:0] sof_second = SOF_SECOND_RST;
  logic [BYTE_W-1:0] frame_type = FRAME_TYPE_RST;

  // Parser state of the predictor.
  parse_state_t      hunt_state;
  logic [5:0]        frame_pos;
  logic [5:0]        frame_total;
  logic [BYTE_W-1:0] frame_sum;
  logic [BYTE_W-1:0] pay_store [STORE_DEPTH];

  rx_beat_t      rx_q[$];
  payload_beat_t payload_q[$];
  payload_beat_t want;

  bit          idle_on;
  bit          in_fire;
  bit          out_fire;
  bit          cfg_fire;
  int unsigned rx_wait;
  int unsigned out_hold;
  int unsigned rx_pushed;
  int unsigned rx_accepted;
  int unsigned payload_beats;
  int unsigned good_frames;
  int unsigned settings;
  int unsigned errors;
  int unsigned cycle_cnt;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void restart_hunt();
    hunt_state  = ST_SOF_FIRST;
    frame_pos   = '0;
    frame_total = '0;
    frame_sum   = '0;
  endfunction

  // Advance the parser by one received byte and queue any payload it releases.
  function automatic void predict_rx(input logic [BYTE_W-1:0] b);
    int unsigned n;
    case (hunt_state)
      ST_SOF_FIRST: begin
        if (b == sof_first) begin
          frame_sum  = b;
          hunt_state = ST_SOF_SECOND;
        end
      end
      ST_SOF_SECOND: begin
        if (b == sof_second) begin
          frame_sum  = frame_sum + b;
          hunt_state = ST_LENGTH;
        end else begin
          restart_hunt();
        end
      end
      ST_LENGTH: begin
        if (int'(b) >= MIN_LENGTH && int'(b) + FRAME_EXTRA <= MAX_FRAME) begin
          frame_total = 6'(int'(b) + FRAME_EXTRA);
          frame_sum   = frame_sum + b;
          hunt_state  = ST_TYPE;
        end else begin
          restart_hunt();
        end
      end
      ST_TYPE: begin
        if (b == frame_type) begin
          frame_sum  = frame_sum + b;
          frame_pos  = 6'(HEADER_BYTES);
          hunt_state = ST_BODY;
        end else begin
          restart_hunt();
        end
      end
      default: begin
        if (int'(frame_pos) + 1 < int'(frame_total)) begin
          if (int'(frame_pos) - HEADER_BYTES < STORE_DEPTH)
            pay_store[int'(frame_pos) - HEADER_BYTES] = b;
          frame_sum = frame_sum + b;
          frame_pos = frame_pos + 1'b1;
        end else begin
          // Checksum byte: release the stored payload only on a match.
          if (b == frame_sum) begin
            n = int'(frame_total) - NON_PAYLOAD;
            for (int k = 0; k < n; k++)
              payload_q.push_back('{pay: pay_store[k], idx: INDEX_W'(k),
                                    last: (k + 1 == n)});
          end
          restart_hunt();
        end
      end
    endcase
  endfunction

  // Sample both channels; the fire flags tell the drivers what the edge accepted.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    in_fire   <= rst_n && in_tvalid && in_tready;
    out_fire  <= rst_n && out_tvalid && out_tready;
    cfg_fire  <= rst_n && cfg_valid && cfg_ready;
    if (!rst_n) begin
      restart_hunt();
    end else begin
      if (out_tvalid && out_tready) begin
        payload_beats++;
        if (out_tlast)
          good_frames++;
        if (payload_q.size() == 0) begin
          $display("%0t: unexpected payload beat: expected none, actual data=%h idx=%0d last=%b",
                   $time, out_tdata[7:0], out_tdata[12:8], out_tlast);
          errors++;
        end else begin
          want = payload_q.pop_front();
          if (out_tdata[7:0] !== want.pay) begin
            $display("%0t: payload_byte expected %h actual %h", $time, want.pay, out_tdata[7:0]);
            errors++;
          end
          if (out_tdata[12:8] !== want.idx) begin
            $display("%0t: payload_index expected %0d actual %0d", $time, want.idx,
                     out_tdata[12:8]);
            errors++;
          end
          if (out_tlast !== want.last) begin
            $display("%0t: last expected %b actual %b", $time, want.last, out_tlast);
            errors++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        predict_rx(in_tdata);
        rx_accepted++;
      end
    end
  end

  // Byte driver: each queued beat waits out its own gap before it is offered.
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_fire)) begin
      if (rx_q.size() == 0) begin
        in_tvalid <= 1'b0;
      end else if (rx_wait < rx_q[0].gap) begin
        rx_wait++;
        in_tvalid <= 1'b0;
      end else begin
        in_tvalid <= 1'b1;
        in_tdata  <= rx_q[0].data;
        void'(rx_q.pop_front());
        rx_wait = 0;
      end
    end
  end

  // Receiver: while idle_on is set, a fresh stall is drawn per payload beat, and now and
  // then while idle so that the first beat of a run can meet a low ready too.
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_fire)
        out_hold = idle_on ? $urandom_range(0, MAX_GAP) : 0;
      else if (idle_on && !out_tvalid && out_hold == 0 && $urandom_range(0, 15) == 0)
        out_hold = $urandom_range(1, MAX_GAP);
      if (out_hold > 0) begin
        out_hold--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    while (cycle_cnt < RUN_LIMIT) @(posedge clk);
    $display("%0t: timeout with %0d payload beats still expected", $time, payload_q.size());
    $display("Mismatches found");
    $finish;
  end

  task automatic push_byte(input logic [BYTE_W-1:0] b);
    rx_q.push_back('{data: b, gap: idle_on ? $urandom_range(0, MAX_GAP) : 0});
    rx_pushed++;
  endtask

  // Whole frame under the current registers; extreme_fill alternates 00 and FF.
  task automatic push_frame(input int unsigned len, input bit good_sum, input bit extreme_fill);
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] b;
    sum = sof_first + sof_second + BYTE_W'(len) + frame_type;
    push_byte(sof_first);
    push_byte(sof_second);
    push_byte(BYTE_W'(len));
    push_byte(frame_type);
    for (int k = 0; k < int'(len) - 2; k++) begin
      b = extreme_fill ? ((k % 2) ? 8'hFF : 8'h00) : BYTE_W'($urandom);
      push_byte(b);
      sum = sum + b;
    end
    push_byte(good_sum ? sum : sum + BYTE_W'($urandom_range(1, 255)));
  endtask

  // Mostly well-formed frames with random content, some with a bad checksum, the rest broken headers and noise.
  task automatic random_traffic(input int unsigned n_bytes);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned len;
    logic [BYTE_W-1:0] b;
    stop_at = rx_pushed + n_bytes;
    while (rx_pushed < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        case ($urandom_range(0, 9))
          0:       len = MAX_FRAME - FRAME_EXTRA;
          1:       len = $urandom_range(11, MAX_FRAME - FRAME_EXTRA - 1);
          default: len = $urandom_range(MIN_LENGTH, 10);
        endcase
        push_frame(len, pick < 68, 1'b0);
      end else if (pick < 90) begin
        push_byte(sof_first);
        case ($urandom_range(0, 2))
          0: begin
            do b = BYTE_W'($urandom); while (b == sof_second);
            push_byte(b);
          end
          1: begin
            push_byte(sof_second);
            if ($urandom_range(0, 1))
              push_byte(BYTE_W'($urandom_range(0, MIN_LENGTH - 1)));
            else
              push_byte(BYTE_W'($urandom_range(MAX_FRAME - FRAME_EXTRA + 1, 255)));
          end
          default: begin
            push_byte(sof_second);
            push_byte(BYTE_W'($urandom_range(MIN_LENGTH, MAX_FRAME - FRAME_EXTRA)));
            do b = BYTE_W'($urandom); while (b == frame_type);
            push_byte(b);
          end
        endcase
      end else begin
        repeat ($urandom_range(1, 4)) push_byte(BYTE_W'($urandom));
      end
    end
  endtask

  // Hold the sender until every byte is taken and every payload beat has come.
  task automatic wait_idle();
    while (rx_accepted != rx_pushed || payload_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_fire);
    cfg_valid <= 1'b0;
    case (idx)
      REG_SOF_FIRST:  sof_first  = val;
      REG_SOF_SECOND: sof_second = val;
      REG_FRAME_TYPE: frame_type = val;
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [BYTE_W-1:0] first, input logic [BYTE_W-1:0] second,
                          input logic [BYTE_W-1:0] ftype);
    wait_idle();
    write_reg(REG_SOF_FIRST, first);
    write_reg(REG_SOF_SECOND, second);
    write_reg(REG_FRAME_TYPE, ftype);
    settings++;
  endtask

  initial begin
    logic [BYTE_W-1:0] same;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    idle_on    = 1'b1;
    settings   = 1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset register values.
    push_frame(4, 1'b1, 1'b1);
    // A repeated first start byte is dropped, and the byte after it is not
    // taken as the second start byte.
    push_byte(sof_first);
    push_byte(sof_first);
    push_byte(sof_second);
    push_byte(sof_first);
    push_byte(sof_second);
    push_byte(BYTE_W'(MIN_LENGTH - 1));
    push_byte(sof_first);
    push_byte(sof_second);
    push_byte(BYTE_W'(MAX_FRAME - FRAME_EXTRA + 1));
    push_byte(sof_first);
    push_byte(sof_second);
    push_byte(BYTE_W'(MIN_LENGTH));
    push_byte(~frame_type);
    push_frame(MIN_LENGTH, 1'b0, 1'b0);
    wait_idle();

    random_traffic(PHASE_BYTES);

    wait_idle();
    write_reg(REG_UNMAPPED, 8'hFF);
    set_regs(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
    idle_on = 1'b0;
    random_traffic(PHASE_BYTES);

    set_regs(8'h00, 8'hFF, 8'h00);
    idle_on = 1'b1;
    random_traffic(PHASE_BYTES);

    set_regs(8'hFF, 8'h00, 8'hFF);
    random_traffic(PHASE_BYTES);

    // All three markers equal.
    same = BYTE_W'($urandom);
    set_regs(same, same, same);
    idle_on = 1'b0;
    random_traffic(PHASE_BYTES / 2);
    idle_on = 1'b1;
    random_traffic(PHASE_BYTES / 2);

    wait_idle();
    $display("Sent %0d received bytes under %0d marker settings.", rx_accepted, settings);
    $display("%0d good frames came out as %0d payload beats.", good_frames, payload_beats);
    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/sofd_pkg.sv
rtl/sofd_cell.sv
rtl/sof_length_checksum_deframer.sv
dv/tb_sof_length_checksum_deframer.sv
